@@ sv/sorted_slot_check_list_top_assert.svh @@
// ----------------------------------------------------------------------------
// Sorted slot check list assertion macros
// Clocked assertion forms used by the check list controller.
// ----------------------------------------------------------------------------
`ifndef SORTED_SLOT_CHECK_LIST_TOP_ASSERT_SVH
`define SORTED_SLOT_CHECK_LIST_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SSCL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define SSCL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) ante |=> cons) else $error(msg);

`endif

@@ sv/sscl_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted slot check list package
// Operation codes, controller states and the command and status words
// shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package sscl_pkg;

   // Slot value that stands for no slot.
   localparam logic [15:0] SLOT_NONE = 16'hFFFF;

   // Operation codes of an input word.
   typedef enum logic [2:0] {
      OP_LOAD   = 3'd0,
      OP_POP    = 3'd1,
      OP_LOOKUP = 3'd2,
      OP_RECORD = 3'd3,
      OP_READ   = 3'd4
   } op_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP_WAIT,
      ST_READ_WAIT,
      ST_LOOK,
      ST_SORT_SCAN,
      ST_SORT_WRITE,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic exec;
      logic pop_take;
      logic read_take;
      logic look_step;
      logic scan_step;
      logic sort_write;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type op;
      logic   last;
      logic   pend_nz;
      logic   idx_ok;
      logic   look_done;
      logic   scan_done;
      logic   last_pos;
      logic   rsp_free;
   } status_type;

endpackage

@@ sv/sscl_datapath.sv @@
// ----------------------------------------------------------------------------
// Sorted slot check list datapath
// Holds the staged pairs, the sorted list and the check results in
// memories, and runs the scans and updates that the controller commands.
// ----------------------------------------------------------------------------
module sscl_datapath import sscl_pkg::*; #(
   parameter int LIST_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [2:0]  req_operation,
   input  logic [15:0] req_slot_in,
   input  logic [7:0]  req_channel_in,
   input  logic        req_busy_in,
   input  logic [3:0]  req_result_index,
   input  logic        req_last_pair,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_slot_out,
   output logic [7:0]  rsp_channel_out,
   output logic        rsp_found,
   output logic        rsp_busy_out,
   output logic        rsp_error,
   input  cmd_type     cmd,
   output status_type  status
);

   localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   // Captured input word.
   op_type      op_ff;
   logic [15:0] slot_ff;
   logic [7:0]  chan_ff;
   logic        busy_ff;
   logic [3:0]  idx_ff;
   logic        last_ff;

   // List bookkeeping.
   logic [CW-1:0]         staged_count_ff;
   logic [CW-1:0]         pending_ff;
   logic [CW-1:0]         done_ff;
   logic                  built_ff;
   logic [LIST_DEPTH-1:0] sorted_valid_ff;
   logic [LIST_DEPTH-1:0] checked_valid_ff;

   // Scan state.
   logic [CW-1:0]         k_ff;
   logic                  dv_ff;
   logic [AW-1:0]         didx_ff;
   logic [CW-1:0]         n_ff;
   logic [CW-1:0]         pos_ff;
   logic [LIST_DEPTH-1:0] taken_ff;
   logic [15:0]           best_ff;
   logic [AW-1:0]         pick_ff;
   logic                  any_ff;
   logic [7:0]            pick_chan_ff;

   // Result scratch and output registers.
   logic [15:0] res_slot_ff;
   logic [7:0]  res_chan_ff;
   logic        res_found_ff;
   logic        res_busy_ff;
   logic        res_err_ff;
   logic        rsp_valid_ff;
   logic [15:0] rsp_slot_ff;
   logic [7:0]  rsp_chan_ff;
   logic        rsp_found_ff;
   logic        rsp_busy_ff;
   logic        rsp_err_ff;

   // Memories and their registered read ports.
   logic [23:0] staged_mem  [LIST_DEPTH];
   logic [23:0] sorted_mem  [LIST_DEPTH];
   logic [16:0] checked_mem [LIST_DEPTH];
   logic [23:0] staged_rd_ff;
   logic [23:0] sorted_rd_ff;
   logic        sorted_vld_rd_ff;
   logic [16:0] checked_rd_ff;
   logic        checked_vld_rd_ff;

   // Derived values.
   logic            stage_ok;
   logic [CW-1:0]   cnt_after;
   logic [CW-1:0]   pend_dec;
   logic [CW-1:0]   done_dec;
   logic [AW+3:0]   idx_ext;
   logic [AW-1:0]   idx_addr;
   logic            idx_ok;
   logic [AW-1:0]   sorted_addr;
   logic [15:0]     sorted_slot_eff;
   logic [7:0]      sorted_chan_eff;
   logic [15:0]     st_slot;
   logic [7:0]      st_chan;
   logic            cand;
   logic            stage_we;
   logic            record_we;

   // Address and condition logic.
   always_comb begin
      stage_ok    = (staged_count_ff != DEPTH_C);
      cnt_after   = staged_count_ff + (stage_ok ? ONE_C : '0);
      pend_dec    = pending_ff - ONE_C;
      done_dec    = done_ff - ONE_C;
      idx_ext     = {{AW{1'b0}}, idx_ff};
      idx_addr    = idx_ext[AW-1:0];
      idx_ok      = ({{CW{1'b0}}, idx_ff} < (CW + 4)'(LIST_DEPTH));
      sorted_addr = (op_ff == OP_POP) ? pend_dec[AW-1:0] : k_ff[AW-1:0];
      stage_we    = cmd.exec && (op_ff == OP_LOAD) && stage_ok;
      record_we   = cmd.exec && (op_ff == OP_RECORD) && (done_ff != '0);
      st_slot     = staged_rd_ff[23:8];
      st_chan     = staged_rd_ff[7:0];
      cand        = !taken_ff[didx_ff] && (st_slot != SLOT_NONE) && (st_slot >= best_ff);
      if (sorted_vld_rd_ff) begin
         sorted_slot_eff = sorted_rd_ff[23:8];
         sorted_chan_eff = sorted_rd_ff[7:0];
      end else begin
         sorted_slot_eff = built_ff ? 16'h0000 : SLOT_NONE;
         sorted_chan_eff = 8'h00;
      end
   end

   // Input word capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= op_type'(req_operation);
         slot_ff <= req_slot_in;
         chan_ff <= req_channel_in;
         busy_ff <= req_busy_in;
         idx_ff  <= req_result_index;
         last_ff <= req_last_pair;
      end
   end

   // Staged pair memory.
   always_ff @(posedge clock) begin
      if (stage_we) begin
         staged_mem[staged_count_ff[AW-1:0]] <= {slot_ff, chan_ff};
      end
      staged_rd_ff <= staged_mem[k_ff[AW-1:0]];
   end

   // Sorted list memory.
   always_ff @(posedge clock) begin
      if (cmd.sort_write) begin
         sorted_mem[pos_ff[AW-1:0]] <= {(any_ff ? best_ff : SLOT_NONE), pick_chan_ff};
      end
      sorted_rd_ff     <= sorted_mem[sorted_addr];
      sorted_vld_rd_ff <= sorted_valid_ff[sorted_addr];
   end

   // Check result memory.
   always_ff @(posedge clock) begin
      if (record_we) begin
         checked_mem[done_dec[AW-1:0]] <= {slot_ff, busy_ff};
      end
      checked_rd_ff     <= checked_mem[idx_addr];
      checked_vld_rd_ff <= checked_valid_ff[idx_addr];
   end

   // Counters and valid bits; the end of a load clears both lists at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         staged_count_ff  <= '0;
         pending_ff       <= '0;
         done_ff          <= '0;
         built_ff         <= 1'b0;
         sorted_valid_ff  <= '0;
         checked_valid_ff <= '0;
      end else if (cmd.exec) begin
         case (op_ff)
            OP_LOAD: begin
               if (last_ff) begin
                  staged_count_ff  <= '0;
                  pending_ff       <= cnt_after;
                  done_ff          <= cnt_after;
                  built_ff         <= 1'b1;
                  sorted_valid_ff  <= '0;
                  checked_valid_ff <= '0;
               end else begin
                  staged_count_ff <= cnt_after;
               end
            end
            OP_POP: begin
               if (pending_ff != '0) begin
                  pending_ff <= pend_dec;
               end
            end
            OP_RECORD: begin
               if (done_ff != '0) begin
                  done_ff                             <= done_dec;
                  checked_valid_ff[done_dec[AW-1:0]] <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.sort_write) begin
         sorted_valid_ff[pos_ff[AW-1:0]] <= 1'b1;
      end
   end

   // Scan control: read issue counter and the read-data valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff  <= '0;
         dv_ff <= 1'b0;
      end else if (cmd.exec || cmd.sort_write) begin
         k_ff  <= '0;
         dv_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         dv_ff   <= (k_ff != n_ff);
         didx_ff <= k_ff[AW-1:0];
         if (k_ff != n_ff) begin
            k_ff <= k_ff + ONE_C;
         end
      end else if (cmd.look_step) begin
         dv_ff <= (k_ff != DEPTH_C);
         if (k_ff != DEPTH_C) begin
            k_ff <= k_ff + ONE_C;
         end
      end
   end

   // Selection of the largest untaken staged slot, later pairs winning ties.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         best_ff <= '0;
         any_ff  <= 1'b0;
         pos_ff  <= '0;
         if (op_ff == OP_LOAD && last_ff) begin
            n_ff     <= cnt_after;
            taken_ff <= '0;
         end
      end else if (cmd.sort_write) begin
         best_ff <= '0;
         any_ff  <= 1'b0;
         pos_ff  <= pos_ff + ONE_C;
         if (any_ff) begin
            taken_ff[pick_ff] <= 1'b1;
         end
      end else if (cmd.scan_step && dv_ff) begin
         if (cand) begin
            best_ff <= st_slot;
            pick_ff <= didx_ff;
            any_ff  <= 1'b1;
         end
         if (cand || didx_ff == '0) begin
            pick_chan_ff <= st_chan;
         end
      end
   end

   // Result scratch registers.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         res_slot_ff  <= SLOT_NONE;
         res_chan_ff  <= '0;
         res_found_ff <= 1'b0;
         res_busy_ff  <= 1'b0;
         res_err_ff   <= ((op_ff == OP_LOAD) && !stage_ok)
                      || ((op_ff == OP_RECORD) && (done_ff == '0));
      end else if (cmd.pop_take) begin
         res_slot_ff <= sorted_slot_eff;
      end else if (cmd.read_take) begin
         res_slot_ff <= checked_vld_rd_ff ? checked_rd_ff[16:1] : 16'h0000;
         res_busy_ff <= checked_vld_rd_ff && checked_rd_ff[0];
      end else if (cmd.look_step && dv_ff && !res_found_ff) begin
         if (sorted_slot_eff == slot_ff) begin
            res_found_ff <= 1'b1;
            res_chan_ff  <= sorted_chan_eff;
         end
      end
   end

   // Output word register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_slot_ff  <= res_slot_ff;
         rsp_chan_ff  <= res_chan_ff;
         rsp_found_ff <= res_found_ff;
         rsp_busy_ff  <= res_busy_ff;
         rsp_err_ff   <= res_err_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slot_out    = rsp_slot_ff;
   assign rsp_channel_out = rsp_chan_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_busy_out    = rsp_busy_ff;
   assign rsp_error       = rsp_err_ff;

   // Status toward the controller.
   always_comb begin
      status.op        = op_ff;
      status.last      = last_ff;
      status.pend_nz   = (pending_ff != '0);
      status.idx_ok    = idx_ok;
      status.look_done = res_found_ff || ((k_ff == DEPTH_C) && !dv_ff);
      status.scan_done = (k_ff == n_ff) && !dv_ff;
      status.last_pos  = ((pos_ff + ONE_C) == n_ff);
      status.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

endmodule

@@ sv/sscl_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sorted slot check list controller
// State machine that accepts one word at a time and sequences the
// datapath through execution, list scans, sorting and the result handoff.
// ----------------------------------------------------------------------------
`include "sorted_slot_check_list_top_assert.svh"

module sscl_ctrl import sscl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            case (status.op)
               OP_LOAD:   state_in = status.last ? ST_SORT_SCAN : ST_RESP;
               OP_POP:    state_in = status.pend_nz ? ST_POP_WAIT : ST_RESP;
               OP_LOOKUP: state_in = ST_LOOK;
               OP_READ:   state_in = status.idx_ok ? ST_READ_WAIT : ST_RESP;
               default:   state_in = ST_RESP;
            endcase
         end
         ST_POP_WAIT: begin
            cmd.pop_take = 1'b1;
            state_in     = ST_RESP;
         end
         ST_READ_WAIT: begin
            cmd.read_take = 1'b1;
            state_in      = ST_RESP;
         end
         ST_LOOK: begin
            if (status.look_done) begin
               state_in = ST_RESP;
            end else begin
               cmd.look_step = 1'b1;
            end
         end
         ST_SORT_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_SORT_WRITE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_SORT_WRITE: begin
            cmd.sort_write = 1'b1;
            state_in       = status.last_pos ? ST_RESP : ST_SORT_SCAN;
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // An accepted word always starts execution in the next cycle.
   `SSCL_ASSERT_NEXT(a_accept_exec, req_valid && req_ready, state_ff == ST_EXEC, "accepted word did not start execution")
   // A list position is written only after a completed scan.
   `SSCL_ASSERT(a_write_after_scan, state_ff == ST_SORT_WRITE |-> $past(state_ff) == ST_SORT_SCAN && $past(status.scan_done), "sorted entry written without a finished scan")
   // The pop read wait only follows a pop on a list that held entries.
   `SSCL_ASSERT(a_pop_nonempty, state_ff == ST_POP_WAIT |-> $past(status.pend_nz) && $past(state_ff) == ST_EXEC, "pop read started on an empty list")

endmodule

@@ sv/sorted_slot_check_list_top.sv @@
// ----------------------------------------------------------------------------
// Sorted slot check list
// Keeps a sorted list of (slot, channel) pairs to check and a store of
// check results, driven by load, pop, lookup, record and read words.
// ----------------------------------------------------------------------------
// Usage: each request word carries an operation and its fields; every
// request produces exactly one response word. Both channels use
// valid/ready and a word moves when both are high.
// One word is worked at a time. A lookup walks the sorted list memory
// one entry per cycle and stops early on a match. A load that ends a
// batch sorts the n staged pairs by selection, one staged memory read per
// cycle. The next request is taken in the cycle after its response is
// loaded. The response sits in an output register, so the next request is
// taken while it waits; a stalled receiver holds the block only once the
// next response is ready. Reset empties the staged batch, the sorted list
// (all slots read as none) and the result store.
// ----------------------------------------------------------------------------
module sorted_slot_check_list_top import sscl_pkg::*; #(
   parameter int LIST_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [15:0] req_slot_in,
   input  logic [7:0]  req_channel_in,
   input  logic        req_busy_in,
   input  logic [3:0]  req_result_index,
   input  logic        req_last_pair,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_slot_out,
   output logic [7:0]  rsp_channel_out,
   output logic        rsp_found,
   output logic        rsp_busy_out,
   output logic        rsp_error
);

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   sscl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage and compute.
   sscl_datapath #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_operation),
      .req_slot_in      (req_slot_in),
      .req_channel_in   (req_channel_in),
      .req_busy_in      (req_busy_in),
      .req_result_index (req_result_index),
      .req_last_pair    (req_last_pair),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_slot_out     (rsp_slot_out),
      .rsp_channel_out  (rsp_channel_out),
      .rsp_found        (rsp_found),
      .rsp_busy_out     (rsp_busy_out),
      .rsp_error        (rsp_error),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
